FILE: hw/rtl/fvpc_pkg.sv
// fvpc_pkg: shared types and constants of the furnace valve pump controller
// transaction payload structs, configuration register map, error codes
// no dependencies
package fvpc_pkg;

  localparam int FURNACES_DEFAULT = 2;
  localparam int MAX_FURNACES     = 4;
  localparam int MS_PER_SECOND    = 1000;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int TRAVEL_MS_W = 18;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VALVE_OPEN_MARGIN    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VALVE_CLOSE_MARGIN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_ON_TEMP         = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PUMP_OFF_HYSTERESIS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_VALVE_TRAVEL_SECONDS = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_COUNT       = 3'd1;
  localparam logic [2:0] ERR_SENSOR_BASE = 3'd2;

  typedef struct packed {
    logic        [3:0]  sensor_count;
    logic signed [11:0] water_temp;
    logic signed [11:0] furnace_temp_a;
    logic signed [11:0] furnace_temp_b;
    logic signed [11:0] furnace_temp_c;
    logic signed [11:0] furnace_temp_d;
    logic        [4:0]  invalid_mask;
    logic               winter;
    logic        [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pump_drive;
    logic       valve_open_drive;
    logic       valve_close_drive;
    logic       error_lamp;
    logic [2:0] error_code;
    logic [2:0] last_error_code;
    logic [1:0] active_furnace;
    logic       valve_is_open;
    logic       pump_running;
    logic       controlled;
  } out_item_t;

  typedef struct packed {
    logic signed [10:0]            valve_open_margin;
    logic signed [10:0]            valve_close_margin;
    logic signed [11:0]            pump_on_temp;
    logic        [9:0]             pump_off_hysteresis;
    logic        [TRAVEL_MS_W-1:0] valve_travel_ms;
  } cfg_t;

endpackage

FILE: hw/rtl/fvpc_cfg_regs.sv
// fvpc_cfg_regs: configuration register file of the controller
// keeps valve travel time already scaled to milliseconds
// depends on fvpc_pkg
module fvpc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fvpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [fvpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output fvpc_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valve_open_margin   <= 11'sd0;
      cfg.valve_close_margin  <= 11'sd0;
      cfg.pump_on_temp        <= 12'sd480;
      cfg.pump_off_hysteresis <= 10'd32;
      cfg.valve_travel_ms     <= fvpc_pkg::TRAVEL_MS_W'(30 * fvpc_pkg::MS_PER_SECOND);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fvpc_pkg::CFG_VALVE_OPEN_MARGIN: begin
          cfg.valve_open_margin <= $signed(cfg_data[10:0]);
        end
        fvpc_pkg::CFG_VALVE_CLOSE_MARGIN: begin
          cfg.valve_close_margin <= $signed(cfg_data[10:0]);
        end
        fvpc_pkg::CFG_PUMP_ON_TEMP: begin
          cfg.pump_on_temp <= $signed(cfg_data[11:0]);
        end
        fvpc_pkg::CFG_PUMP_OFF_HYSTERESIS: begin
          cfg.pump_off_hysteresis <= cfg_data[9:0];
        end
        fvpc_pkg::CFG_VALVE_TRAVEL_SECONDS: begin
          // constant multiply, small
          cfg.valve_travel_ms <= fvpc_pkg::TRAVEL_MS_W'(cfg_data[7:0])
                               * fvpc_pkg::TRAVEL_MS_W'(fvpc_pkg::MS_PER_SECOND);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/fvpc_step.sv
// fvpc_step: controller state and the per-update decision logic
// count check, sensor failure, warmest furnace, pump and valve rules, motor timing
// depends on fvpc_pkg
module fvpc_step #(
  parameter int FURNACES = fvpc_pkg::FURNACES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  fvpc_pkg::cfg_t      cfg,
  input  fvpc_pkg::in_item_t  item,
  input  logic                advance,
  output fvpc_pkg::out_item_t result_next
);

  localparam logic [3:0] ALL_PUMPS = 4'((1 << FURNACES) - 1);
  localparam logic [3:0] COUNT_OK  = 4'(FURNACES + 1);
  localparam int         MAX_FURN  = fvpc_pkg::MAX_FURNACES;

  logic [2:0]  err_now, err_last;
  logic        lamp_latch, valve_pos;
  logic        opening_live, closing_live;
  logic [31:0] opening_start, closing_start;
  logic        pump_flag;
  logic [3:0]  pump_bits;
  logic        open_drive_reg, close_drive_reg;
  logic        first_pass, count_checked;
  logic [1:0]  chosen_furnace;

  logic [2:0]  err_now_next, err_last_next;
  logic        lamp_latch_next, valve_pos_next;
  logic        opening_live_next, closing_live_next;
  logic [31:0] opening_start_next, closing_start_next;
  logic        pump_flag_next;
  logic [3:0]  pump_bits_next;
  logic        open_drive_reg_next, close_drive_reg_next;
  logic        first_pass_next, count_checked_next;
  logic [1:0]  chosen_furnace_next;
  logic        controlled;

  logic signed [11:0] ft [MAX_FURN];

  assign ft[0] = item.furnace_temp_a;
  assign ft[1] = item.furnace_temp_b;
  assign ft[2] = item.furnace_temp_c;
  assign ft[3] = item.furnace_temp_d;

  always_comb begin
    logic               done;
    logic [2:0]         fail;
    logic [1:0]         ch;
    logic signed [12:0] t;
    logic signed [12:0] open_lvl, close_lvl, on_lvl, off_lvl;
    logic               should_open, should_close, open_s, close_s;
    logic               opening, closing;

    err_now_next         = err_now;
    err_last_next        = err_last;
    lamp_latch_next      = lamp_latch;
    valve_pos_next       = valve_pos;
    opening_live_next    = opening_live;
    closing_live_next    = closing_live;
    opening_start_next   = opening_start;
    closing_start_next   = closing_start;
    pump_flag_next       = pump_flag;
    pump_bits_next       = pump_bits;
    open_drive_reg_next  = open_drive_reg;
    close_drive_reg_next = close_drive_reg;
    first_pass_next      = first_pass;
    count_checked_next   = count_checked;
    chosen_furnace_next  = chosen_furnace;
    controlled           = 1'b0;
    done                 = 1'b0;
    fail                 = fvpc_pkg::ERR_NONE;
    ch                   = 2'd0;
    t                    = 13'sd0;
    open_lvl             = 13'sd0;
    close_lvl            = 13'sd0;
    on_lvl               = 13'sd0;
    off_lvl              = 13'sd0;
    should_open          = 1'b0;
    should_close         = 1'b0;
    open_s               = 1'b0;
    close_s              = 1'b0;
    opening              = 1'b0;
    closing              = 1'b0;

    // count check on the first update and while a count error is pending
    if (!count_checked || err_now == fvpc_pkg::ERR_COUNT) begin
      count_checked_next = 1'b1;
      if (item.sensor_count != COUNT_OK) begin
        err_now_next         = fvpc_pkg::ERR_COUNT;
        err_last_next        = fvpc_pkg::ERR_COUNT;
        lamp_latch_next      = 1'b1;
        pump_bits_next       = ALL_PUMPS;
        valve_pos_next       = 1'b1;
        open_drive_reg_next  = 1'b1;
        close_drive_reg_next = 1'b0;
        done                 = 1'b1;
      end else begin
        err_now_next = fvpc_pkg::ERR_NONE;
        if (count_checked) begin
          done = 1'b1;
        end
      end
    end

    // highest failing sensor wins
    if (!done) begin
      for (int i = 0; i <= FURNACES; i++) begin
        if (item.invalid_mask[3'(i)]) begin
          fail = fvpc_pkg::ERR_SENSOR_BASE + 3'(i);
        end
      end
      if (fail != fvpc_pkg::ERR_NONE) begin
        err_now_next         = fail;
        err_last_next        = fail;
        lamp_latch_next      = 1'b1;
        pump_bits_next       = ALL_PUMPS;
        valve_pos_next       = 1'b1;
        open_drive_reg_next  = 1'b1;
        close_drive_reg_next = 1'b0;
        done                 = 1'b1;
      end else begin
        err_now_next = fvpc_pkg::ERR_NONE;
      end
    end

    if (!done) begin
      controlled = 1'b1;
      // warmest furnace, ties keep the lower index
      for (int i = 1; i < FURNACES; i++) begin
        if (ft[2'(i)] > ft[ch]) begin
          ch = 2'(i);
        end
      end
      chosen_furnace_next = ch;
      t         = 13'(ft[ch]);
      open_lvl  = 13'(item.water_temp) + 13'(cfg.valve_open_margin);
      close_lvl = 13'(item.water_temp) + 13'(cfg.valve_close_margin);
      on_lvl    = 13'(cfg.pump_on_temp);
      off_lvl   = on_lvl - $signed({3'b000, cfg.pump_off_hysteresis});
      should_open  = t >= open_lvl;
      should_close = t < close_lvl;

      if (first_pass) begin
        if (should_close) begin
          valve_pos_next = 1'b1;
        end
        if (should_open) begin
          valve_pos_next = 1'b0;
        end
        first_pass_next = 1'b0;
      end

      if (item.winter) begin
        if (t >= on_lvl) begin
          pump_bits_next = 4'(4'b0001 << ch) & ALL_PUMPS;
          pump_flag_next = 1'b1;
        end
        // stop is checked after start: zero hysteresis ends with the pump off
        if (t <= off_lvl) begin
          pump_bits_next = 4'b0000;
          pump_flag_next = 1'b0;
        end
      end else if (valve_pos_next) begin
        pump_bits_next = 4'(4'b0001 << ch) & ALL_PUMPS;
        pump_flag_next = 1'b1;
      end else begin
        pump_bits_next = 4'b0000;
        pump_flag_next = 1'b0;
      end

      open_s  = item.winter ? (should_open && pump_flag_next) : should_open;
      close_s = item.winter ? (should_close || !pump_flag_next) : should_close;

      if (open_s && !valve_pos_next) begin
        valve_pos_next     = 1'b1;
        opening_live_next  = 1'b1;
        opening_start_next = item.now_ms;
        closing_live_next  = 1'b0;
      end else if (close_s && valve_pos_next) begin
        valve_pos_next     = 1'b0;
        closing_live_next  = 1'b1;
        closing_start_next = item.now_ms;
        opening_live_next  = 1'b0;
        // summer pump follows the valve, now closed
        if (!item.winter) begin
          pump_bits_next = 4'b0000;
          pump_flag_next = 1'b0;
        end
      end

      // elapsed time wraps modulo 2^32
      opening = opening_live_next &&
                ((item.now_ms - opening_start_next) < 32'(cfg.valve_travel_ms));
      closing = closing_live_next &&
                ((item.now_ms - closing_start_next) < 32'(cfg.valve_travel_ms));
      if (!opening) begin
        opening_live_next = 1'b0;
      end
      if (!closing) begin
        closing_live_next = 1'b0;
      end
      if (opening) begin
        open_drive_reg_next  = 1'b1;
        close_drive_reg_next = 1'b0;
      end
      if (closing) begin
        open_drive_reg_next  = 1'b0;
        close_drive_reg_next = 1'b1;
      end
      if (!opening && !closing) begin
        open_drive_reg_next  = 1'b0;
        close_drive_reg_next = 1'b0;
      end
    end
  end

  always_comb begin
    result_next.pump_drive        = pump_bits_next;
    result_next.valve_open_drive  = open_drive_reg_next;
    result_next.valve_close_drive = close_drive_reg_next;
    result_next.error_lamp        = lamp_latch_next;
    result_next.error_code        = err_now_next;
    result_next.last_error_code   = err_last_next;
    result_next.active_furnace    = chosen_furnace_next;
    result_next.valve_is_open     = valve_pos_next;
    result_next.pump_running      = pump_flag_next;
    result_next.controlled        = controlled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_now         <= fvpc_pkg::ERR_NONE;
      err_last        <= fvpc_pkg::ERR_NONE;
      lamp_latch      <= 1'b0;
      valve_pos       <= 1'b0;
      opening_live    <= 1'b0;
      opening_start   <= 32'd0;
      closing_live    <= 1'b0;
      closing_start   <= 32'd0;
      pump_flag       <= 1'b0;
      pump_bits       <= ALL_PUMPS;
      open_drive_reg  <= 1'b1;
      close_drive_reg <= 1'b0;
      first_pass      <= 1'b1;
      count_checked   <= 1'b0;
      chosen_furnace  <= 2'd0;
    end else if (advance) begin
      err_now         <= err_now_next;
      err_last        <= err_last_next;
      lamp_latch      <= lamp_latch_next;
      valve_pos       <= valve_pos_next;
      opening_live    <= opening_live_next;
      opening_start   <= opening_start_next;
      closing_live    <= closing_live_next;
      closing_start   <= closing_start_next;
      pump_flag       <= pump_flag_next;
      pump_bits       <= pump_bits_next;
      open_drive_reg  <= open_drive_reg_next;
      close_drive_reg <= close_drive_reg_next;
      first_pass      <= first_pass_next;
      count_checked   <= count_checked_next;
      chosen_furnace  <= chosen_furnace_next;
    end
  end

endmodule

FILE: hw/rtl/furnace_valve_pump_controller_top.sv
// furnace_valve_pump_controller_top: top level of the furnace valve pump controller
// input register, decision step, result register; config register file
// depends on fvpc_pkg, fvpc_cfg_regs, fvpc_step

// Takes one update transaction per clock while the result is not stalled and
// returns one result transaction for each, in order. An update sits in the
// input register while the decision logic evaluates it against the controller
// state, then the result register holds the answer once that slot is free. The
// input register takes a new update while the held one moves on, so updates
// flow back to back through the single registered pass of the decision logic.
// A stalled result blocks only the input register behind it. The user must make
// configuration writes only while no update is in flight; the block itself does
// not enforce it.
module furnace_valve_pump_controller_top #(
  parameter int FURNACES = fvpc_pkg::FURNACES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  fvpc_pkg::in_item_t               item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output fvpc_pkg::out_item_t              result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fvpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fvpc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [3:0] ALL_PUMPS = 4'((1 << FURNACES) - 1);

  fvpc_pkg::cfg_t      cfg;
  fvpc_pkg::in_item_t  item_q;
  logic                item_q_valid;
  logic                advance;
  fvpc_pkg::out_item_t result_next;

  fvpc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fvpc_step #(
    .FURNACES (FURNACES)
  ) u_step (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item        (item_q),
    .advance     (advance),
    .result_next (result_next)
  );

  // move the held update into the result register when that slot frees
  assign advance    = item_q_valid && (!result_valid || !result_stall);
  assign item_stall = item_q_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // control only runs on an error-free update
  a_ctl_no_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.controlled |-> result.error_code == fvpc_pkg::ERR_NONE)
    else $error("controlled result carries an error code");

  // the valve motor is never driven both ways
  a_drive_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.valve_open_drive && result.valve_close_drive))
    else $error("valve driven open and closed at once");

  // a live error is latched on the lamp and recorded as the last error
  a_error_latched: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_code != fvpc_pkg::ERR_NONE |->
      result.error_lamp && result.last_error_code == result.error_code)
    else $error("error not latched");

  // no pump outside the fitted furnaces
  a_pump_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.pump_drive & ~ALL_PUMPS) == 4'b0000)
    else $error("pump drive beyond fitted furnaces");

  // a result is loaded only from a held update
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    !item_q_valid && !(result_valid && result_stall) |=> !result_valid)
    else $error("result shown without an update");

endmodule
